// File: sv/fdpc_pkg.sv
// Shared constants for the fan duty controller: default widths, register
// indexes, operation codes and register reset values. No dependencies.
package fdpc_pkg;

    localparam int DUTY_BITS_DEF = 8;
    localparam int TEMP_BITS_DEF = 13;
    localparam int HYST_BITS     = 12;
    localparam int GAIN_BITS     = 12;
    localparam int GAIN_SHIFT    = 8;   // gain carries four fraction bits, temp four more
    localparam int REG_IDX_BITS  = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_AUTO_MODE    = 3'd0,
        REG_SETPOINT     = 3'd1,
        REG_HYSTERESIS   = 3'd2,
        REG_GAIN         = 3'd3,
        REG_SAFETY_TEMP  = 3'd4,
        REG_DUTY_FLOOR   = 3'd5,
        REG_DUTY_CEILING = 3'd6,
        REG_RAMP_STEP    = 3'd7
    } reg_idx_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_SET    = 1'b1
    } op_t;

    localparam int RST_AUTO_MODE    = 1;
    localparam int RST_SETPOINT     = 640;
    localparam int RST_HYSTERESIS   = 32;
    localparam int RST_GAIN         = 320;
    localparam int RST_SAFETY_TEMP  = 1280;
    localparam int RST_DUTY_FLOOR   = 50;
    localparam int RST_DUTY_CEILING = 255;
    localparam int RST_RAMP_STEP    = 5;

endpackage

// File: sv/fdpc_target.sv
// Target duty law: set requests, safety override, deadband, proportional term and clamps.
// Pure combinational; uses fdpc_pkg.
module fdpc_target #(
    parameter int DUTY_BITS = fdpc_pkg::DUTY_BITS_DEF,
    parameter int TEMP_BITS = fdpc_pkg::TEMP_BITS_DEF
) (
    input  logic                          operation,
    input  logic [TEMP_BITS-1:0]          temperature,
    input  logic [DUTY_BITS-1:0]          duty_request,
    input  logic [DUTY_BITS-1:0]          goal_now,
    input  logic                          auto_mode,
    input  logic [TEMP_BITS-1:0]          setpoint,
    input  logic [fdpc_pkg::HYST_BITS-1:0] hysteresis,
    input  logic [fdpc_pkg::GAIN_BITS-1:0] gain,
    input  logic [TEMP_BITS-1:0]          safety_temp,
    input  logic [DUTY_BITS-1:0]          duty_floor,
    input  logic [DUTY_BITS-1:0]          duty_ceiling,
    output logic [DUTY_BITS-1:0]          goal_next,
    output logic                          safety_active
);
    import fdpc_pkg::*;

    localparam int ERR_W  = TEMP_BITS + 1;
    localparam int CMP_W  = (ERR_W > HYST_BITS) ? ERR_W : HYST_BITS;
    localparam int PROD_W = TEMP_BITS + GAIN_BITS;
    localparam int P_W    = PROD_W - GAIN_SHIFT;
    localparam int CL_W   = (P_W > DUTY_BITS) ? P_W : DUTY_BITS;

    logic signed [ERR_W-1:0]  err;
    logic        [ERR_W-1:0]  mag;
    logic                     in_band;
    logic                     err_pos;
    logic        [PROD_W-1:0] prod;
    logic        [CL_W-1:0]   scaled;
    logic        [CL_W-1:0]   floored;
    logic        [CL_W-1:0]   clamped;
    logic                     at_safety;

    always_comb
    begin
        err       = $signed({temperature[TEMP_BITS-1], temperature})
                  - $signed({setpoint[TEMP_BITS-1], setpoint});
        mag       = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        in_band   = CMP_W'(mag) < CMP_W'(hysteresis);
        err_pos   = !err[ERR_W-1] && (err != '0);
        // positive error fits TEMP_BITS unsigned
        prod      = PROD_W'(err[TEMP_BITS-1:0]) * PROD_W'(gain);
        scaled    = CL_W'(prod[PROD_W-1:GAIN_SHIFT]);
        floored   = (scaled < CL_W'(duty_floor)) ? CL_W'(duty_floor) : scaled;
        clamped   = (floored > CL_W'(duty_ceiling)) ? CL_W'(duty_ceiling) : floored;
        at_safety = $signed(temperature) >= $signed(safety_temp);

        goal_next     = goal_now;
        safety_active = 1'b0;
        if (operation == OP_SET)
        begin
            goal_next = (duty_request > duty_ceiling) ? duty_ceiling : duty_request;
        end
        else if (at_safety)
        begin
            safety_active = 1'b1;
            goal_next     = duty_ceiling;
        end
        else if (auto_mode)
        begin
            priority if (in_band)
            begin
                goal_next = goal_now;
            end
            else if (!err_pos)
            begin
                goal_next = '0;
            end
            else
            begin
                goal_next = clamped[DUTY_BITS-1:0];
            end
        end
    end

endmodule

// File: sv/fan_duty_p_control_ramp_unit.sv
// Top level of the fan duty controller: input register, duty/goal state,
// slew limiter and output register. Uses fdpc_pkg and fdpc_target.
//
// Fan duty controller with a proportional law, deadband and slew limit. Each
// transaction either sets a requested target duty or carries a temperature
// sample; each produces exactly one result transaction with the ramped duty,
// the target and a safety flag. An item passes an input register and then the
// result register before its result is offered, and one item per cycle is
// sustained while m_tready holds: the duty/goal update for an item completes
// as it leaves the input register, ahead of the next one. Configuration
// registers are written through the write port; the user must write them
// only while no transaction is in flight. The block does not enforce this.
module fan_duty_p_control_ramp_unit #(
    parameter int DUTY_BITS = fdpc_pkg::DUTY_BITS_DEF,
    parameter int TEMP_BITS = fdpc_pkg::TEMP_BITS_DEF,
    localparam int IN_W   = ((TEMP_BITS + DUTY_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((2 * DUTY_BITS + 7) / 8) * 8,
    localparam int CFG_W0 = (TEMP_BITS > fdpc_pkg::HYST_BITS) ? TEMP_BITS : fdpc_pkg::HYST_BITS,
    localparam int CFG_W  = (CFG_W0 > DUTY_BITS) ? CFG_W0 : DUTY_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_W-1:0]                   s_tdata,   // temperature, duty_request, zero pad
    input  logic                              s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_W-1:0]                  m_tdata,   // duty, target_duty, zero pad
    output logic                              m_tuser,   // safety_active
    input  logic                              cfg_wr_en,
    input  logic [fdpc_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                  cfg_data
);
    import fdpc_pkg::*;

    // configuration
    logic                 auto_mode_reg;
    logic [TEMP_BITS-1:0] setpoint_reg;
    logic [HYST_BITS-1:0] hysteresis_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    logic [TEMP_BITS-1:0] safety_temp_reg;
    logic [DUTY_BITS-1:0] duty_floor_reg;
    logic [DUTY_BITS-1:0] duty_ceiling_reg;
    logic [DUTY_BITS-1:0] ramp_step_reg;

    // input stage
    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [TEMP_BITS-1:0] in_temp_reg;
    logic [DUTY_BITS-1:0] in_req_reg;

    // state
    logic [DUTY_BITS-1:0] duty_reg;
    logic [DUTY_BITS-1:0] duty_next;
    logic [DUTY_BITS-1:0] goal_reg;
    logic [DUTY_BITS-1:0] goal_next;
    logic                 safe_next;

    // output stage
    logic                 out_valid_reg;
    logic [DUTY_BITS-1:0] out_duty_reg;
    logic [DUTY_BITS-1:0] out_goal_reg;
    logic                 out_safe_reg;

    logic                 out_free;
    logic                 advance;
    logic                 s_fire;
    logic [DUTY_BITS:0]   duty_plus;
    logic [DUTY_BITS:0]   goal_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg    <= 1'(RST_AUTO_MODE);
            setpoint_reg     <= TEMP_BITS'(RST_SETPOINT);
            hysteresis_reg   <= HYST_BITS'(RST_HYSTERESIS);
            gain_reg         <= GAIN_BITS'(RST_GAIN);
            safety_temp_reg  <= TEMP_BITS'(RST_SAFETY_TEMP);
            duty_floor_reg   <= DUTY_BITS'(RST_DUTY_FLOOR);
            duty_ceiling_reg <= DUTY_BITS'(RST_DUTY_CEILING);
            ramp_step_reg    <= DUTY_BITS'(RST_RAMP_STEP);
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_AUTO_MODE:    auto_mode_reg    <= cfg_data[0];
                REG_SETPOINT:     setpoint_reg     <= cfg_data[TEMP_BITS-1:0];
                REG_HYSTERESIS:   hysteresis_reg   <= cfg_data[HYST_BITS-1:0];
                REG_GAIN:         gain_reg         <= cfg_data[GAIN_BITS-1:0];
                REG_SAFETY_TEMP:  safety_temp_reg  <= cfg_data[TEMP_BITS-1:0];
                REG_DUTY_FLOOR:   duty_floor_reg   <= cfg_data[DUTY_BITS-1:0];
                REG_DUTY_CEILING: duty_ceiling_reg <= cfg_data[DUTY_BITS-1:0];
                REG_RAMP_STEP:    ramp_step_reg    <= cfg_data[DUTY_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_op_reg   <= s_tuser;
            in_temp_reg <= s_tdata[TEMP_BITS-1:0];
            in_req_reg  <= s_tdata[TEMP_BITS +: DUTY_BITS];
        end
    end

    fdpc_target #(
        .DUTY_BITS (DUTY_BITS),
        .TEMP_BITS (TEMP_BITS)
    ) u_target (
        .operation     (in_op_reg),
        .temperature   (in_temp_reg),
        .duty_request  (in_req_reg),
        .goal_now      (goal_reg),
        .auto_mode     (auto_mode_reg),
        .setpoint      (setpoint_reg),
        .hysteresis    (hysteresis_reg),
        .gain          (gain_reg),
        .safety_temp   (safety_temp_reg),
        .duty_floor    (duty_floor_reg),
        .duty_ceiling  (duty_ceiling_reg),
        .goal_next     (goal_next),
        .safety_active (safe_next)
    );

    // slew toward the new goal, never past it; a set request leaves duty alone
    always_comb
    begin
        duty_plus = {1'b0, duty_reg} + {1'b0, ramp_step_reg};
        goal_plus = {1'b0, goal_next} + {1'b0, ramp_step_reg};
        duty_next = duty_reg;
        if (in_op_reg == OP_SAMPLE)
        begin
            priority if (duty_reg < goal_next)
            begin
                duty_next = (duty_plus > {1'b0, goal_next}) ? goal_next
                                                            : duty_plus[DUTY_BITS-1:0];
            end
            else if (duty_reg > goal_next)
            begin
                duty_next = ({1'b0, duty_reg} < goal_plus) ? goal_next
                                                           : duty_reg - ramp_step_reg;
            end
            else
            begin
                duty_next = duty_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg      <= '0;
            goal_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                duty_reg <= duty_next;
                goal_reg <= goal_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_duty_reg <= duty_next;
            out_goal_reg <= goal_next;
            out_safe_reg <= safe_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_safe_reg;
    assign m_tdata  = OUT_W'({out_goal_reg, out_duty_reg});

`ifndef ASSERT_OFF
    a_safety_forces_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[2*DUTY_BITS-1:DUTY_BITS] == duty_ceiling_reg)
        else $error("safety result without ceiling target");

    a_set_keeps_duty: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_SET) |=> $stable(duty_reg))
        else $error("duty moved on a set request");

    a_no_overshoot_up: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (duty_reg <= goal_next) |=> duty_reg <= goal_reg)
        else $error("ramp overshot the goal");
`endif

endmodule
